// ----- rtl/gsolv_pkg.sv -----
// shared types and constants of the gaussian elimination solver
package gsolv_pkg;

    localparam int DW        = 32;
    localparam int FRAC      = 16;
    localparam int CFG_DW    = 32;
    localparam int CFG_AW    = 3;
    localparam int OW        = 4;
    localparam int OUT_IW    = 3;
    localparam int REG_ORDER = 0;
    localparam logic [OW-1:0] ORDER_RESET = 4'd3;

    typedef enum logic [4:0] {
        S_LOAD,
        S_PIV_RD,
        S_PIV_CHK,
        S_ROW_RD,
        S_ROW_DIV,
        S_ROW_WAIT,
        S_K_RD,
        S_K_MUL,
        S_K_WR,
        S_LAST_RD,
        S_LAST_CHK,
        S_B_RD,
        S_B_ACC,
        S_B_DIV,
        S_B_WAIT,
        S_EMIT,
        S_ERR
    } t_state;

    typedef struct packed {
        logic mem_we;
        logic wsel_in;
        logic mul_ld;
        logic back;
        logic acc_ld_mem;
        logic acc_ld_ms;
        logic piv_ld;
        logic div_start;
        logic ratio_ld;
        logic sol_we;
        logic sol_rd;
        logic out_ld;
        logic out_sing;
        logic out_last;
    } t_cmd;

    typedef struct packed {
        logic rd_b_zero;
        logic div_done;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/gsolv_div.sv -----
// iterative signed q16.16 divider, one quotient bit per cycle, saturating
module gsolv_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [gsolv_pkg::DW-1:0]  i_num,
    input  logic [gsolv_pkg::DW-1:0]  i_den,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [gsolv_pkg::DW-1:0]  o_quot
);
    localparam int DW  = gsolv_pkg::DW;
    localparam int QW  = gsolv_pkg::DW + gsolv_pkg::FRAC;
    localparam int CW  = $clog2(QW + 1);

    logic [DW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_q, n_q;
    logic [DW-1:0] r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;

    logic [DW-1:0] num_mag, den_mag;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;

    assign num_mag = i_num[DW-1] ? (~i_num + 1'b1) : i_num;
    assign den_mag = i_den[DW-1] ? (~i_den + 1'b1) : i_den;

    always_comb begin
        trial = {r_rem, r_q[QW-1]};
        diff  = {1'b0, trial} - {2'b00, r_den};
        if (!diff[DW+1]) begin
            n_rem = diff[DW-1:0];
            n_q   = {r_q[QW-2:0], 1'b1};
        end else begin
            n_rem = trial[DW-1:0];
            n_q   = {r_q[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= {num_mag, {gsolv_pkg::FRAC{1'b0}}};
            r_den <= den_mag;
            r_neg <= i_num[DW-1] ^ i_den[DW-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    always_comb begin
        if (r_neg) begin
            if ((|r_q[QW-1:DW]) || (r_q[DW-1] && (|r_q[DW-2:0]))) begin
                o_quot = {1'b1, {(DW-1){1'b0}}};
            end else begin
                o_quot = ~r_q[DW-1:0] + 1'b1;
            end
        end else begin
            if (|r_q[QW-1:DW-1]) begin
                o_quot = {1'b0, {(DW-1){1'b1}}};
            end else begin
                o_quot = r_q[DW-1:0];
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

// ----- rtl/gsolv_dp.sv -----
// datapath: matrix memory, solution registers, multiply-subtract and divider
module gsolv_dp #(
    parameter int MAX_ORDER = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gsolv_pkg::t_cmd               i_cmd,
    output gsolv_pkg::t_sts               o_sts,
    input  logic [$clog2(MAX_ORDER*(MAX_ORDER+1))-1:0] i_waddr,
    input  logic [$clog2(MAX_ORDER*(MAX_ORDER+1))-1:0] i_raddr_a,
    input  logic [$clog2(MAX_ORDER*(MAX_ORDER+1))-1:0] i_raddr_b,
    input  logic [$clog2(MAX_ORDER)-1:0]  i_sol_widx,
    input  logic [$clog2(MAX_ORDER)-1:0]  i_sol_ridx,
    input  logic [$clog2(MAX_ORDER+1)-1:0] i_out_idx,
    input  logic [gsolv_pkg::DW-1:0]      i_element,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [gsolv_pkg::DW-1:0]      o_solution,
    output logic [gsolv_pkg::OUT_IW-1:0]  o_index,
    output logic                          o_singular,
    output logic                          o_last
);
    localparam int DW    = gsolv_pkg::DW;
    localparam int FRAC  = gsolv_pkg::FRAC;
    localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1);
    localparam int NW    = $clog2(MAX_ORDER + 1);
    localparam int XW    = (NW > gsolv_pkg::OUT_IW) ? NW : gsolv_pkg::OUT_IW;
    localparam int PW    = 2 * DW;
    localparam int SW    = PW - FRAC;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_a, r_rd_b;
    logic [DW-1:0] r_sol [MAX_ORDER];
    logic [DW-1:0] r_sol_hold;
    logic [DW-1:0] r_ratio, r_piv, r_acc, r_a_hold;
    logic signed [PW-1:0] r_prod;
    logic          r_valid;

    logic signed [DW-1:0] mul_x, mul_y;
    logic signed [PW-1:0] wide;
    logic signed [SW-1:0] shifted;
    logic [DW-1:0]        ms_res;
    logic [DW-1:0]        wdata;
    logic [DW-1:0]        div_num;
    logic [DW-1:0]        quot;
    logic                 div_busy, div_done;
    logic [XW-1:0]        idx_ext;

    // matrix store
    assign wdata = i_cmd.wsel_in ? i_element : ms_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[i_waddr] <= wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    // multiply then subtract with floor and saturation
    assign mul_x = i_cmd.back ? $signed(r_rd_a) : $signed(r_ratio);
    assign mul_y = i_cmd.back ? $signed(r_sol_hold) : $signed(r_rd_b);

    always_comb begin
        wide    = $signed({{FRAC{r_a_hold[DW-1]}}, r_a_hold, {FRAC{1'b0}}}) - r_prod;
        shifted = wide[PW-1:FRAC];
        if (!shifted[SW-1] && (|shifted[SW-2:DW-1])) begin
            ms_res = {1'b0, {(DW-1){1'b1}}};
        end else if (shifted[SW-1] && !(&shifted[SW-2:DW-1])) begin
            ms_res = {1'b1, {(DW-1){1'b0}}};
        end else begin
            ms_res = shifted[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_ld) begin
            r_prod   <= mul_x * mul_y;
            r_a_hold <= i_cmd.back ? r_acc : r_rd_a;
        end
        if (i_cmd.acc_ld_mem) begin
            r_acc <= r_rd_a;
        end else if (i_cmd.acc_ld_ms) begin
            r_acc <= ms_res;
        end
        if (i_cmd.piv_ld) begin
            r_piv <= r_rd_b;
        end
        if (i_cmd.ratio_ld) begin
            r_ratio <= quot;
        end
        if (i_cmd.sol_we) begin
            r_sol[i_sol_widx] <= quot;
        end
        if (i_cmd.sol_rd) begin
            r_sol_hold <= r_sol[i_sol_ridx];
        end
    end

    assign div_num = i_cmd.back ? r_acc : r_rd_a;

    gsolv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_piv),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // result register
    assign idx_ext = XW'(i_out_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_solution <= i_cmd.out_sing ? '0 : r_sol[i_sol_ridx];
            o_index    <= i_cmd.out_sing ? '0 : idx_ext[gsolv_pkg::OUT_IW-1:0];
            o_singular <= i_cmd.out_sing;
            o_last     <= i_cmd.out_last;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_sts.rd_b_zero = (r_rd_b == '0);
    assign o_sts.div_done  = div_done;
    assign o_sts.div_busy  = div_busy;
    assign o_sts.out_free  = !r_valid || !i_out_stall;

endmodule

// ----- rtl/gsolv_ctrl.sv -----
// controller: load sequencing, elimination and back substitution loops, result emission
module gsolv_ctrl #(
    parameter int MAX_ORDER = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_ORDER+1)-1:0] i_n,
    input  logic                          i_cfg_wr,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  gsolv_pkg::t_sts               i_sts,
    output gsolv_pkg::t_cmd               o_cmd,
    output logic [$clog2(MAX_ORDER*(MAX_ORDER+1))-1:0] o_waddr,
    output logic [$clog2(MAX_ORDER*(MAX_ORDER+1))-1:0] o_raddr_a,
    output logic [$clog2(MAX_ORDER*(MAX_ORDER+1))-1:0] o_raddr_b,
    output logic [$clog2(MAX_ORDER)-1:0]  o_sol_widx,
    output logic [$clog2(MAX_ORDER)-1:0]  o_sol_ridx,
    output logic [$clog2(MAX_ORDER+1)-1:0] o_out_idx
);
    localparam int ROW_LEN = MAX_ORDER + 1;
    localparam int AW      = $clog2(MAX_ORDER * ROW_LEN);
    localparam int NW      = $clog2(MAX_ORDER + 1);
    localparam int IW      = $clog2(MAX_ORDER);

    gsolv_pkg::t_state r_state, n_state;
    logic [NW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic          r_back, n_back;
    logic [NW-1:0] n_m1;
    logic          accept;

    function automatic logic [AW-1:0] f_addr(input logic [NW-1:0] row,
                                             input logic [NW-1:0] col);
        return AW'(row * ROW_LEN + col);
    endfunction

    assign n_m1   = i_n - 1'b1;
    assign accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsolv_pkg::S_LOAD;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_back  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_back  <= n_back;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_back     = r_back;
        o_cmd      = '0;
        o_cmd.back = r_back;
        o_in_stall = 1'b1;
        o_waddr    = f_addr(r_j, r_k);
        o_raddr_a  = f_addr(r_j, r_i);
        o_raddr_b  = f_addr(r_i, r_i);
        o_sol_widx = r_i[IW-1:0];
        o_sol_ridx = r_j[IW-1:0];
        o_out_idx  = r_i;

        case (r_state)
            gsolv_pkg::S_LOAD: begin
                // r_j is the row and r_k the column while loading
                o_in_stall    = 1'b0;
                o_cmd.wsel_in = 1'b1;
                if (i_cfg_wr) begin
                    n_j = '0;
                    n_k = '0;
                end else if (accept) begin
                    o_cmd.mem_we = 1'b1;
                    if (r_k == i_n) begin
                        n_k = '0;
                        if (r_j == n_m1) begin
                            n_j    = '0;
                            n_i    = '0;
                            n_back = 1'b0;
                            n_state = (i_n == NW'(1)) ? gsolv_pkg::S_LAST_RD
                                                      : gsolv_pkg::S_PIV_RD;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            gsolv_pkg::S_PIV_RD: begin
                o_raddr_b = f_addr(r_i, r_i);
                n_state   = gsolv_pkg::S_PIV_CHK;
            end
            gsolv_pkg::S_PIV_CHK: begin
                if (i_sts.rd_b_zero) begin
                    n_state = gsolv_pkg::S_ERR;
                end else begin
                    o_cmd.piv_ld = 1'b1;
                    n_j          = r_i + 1'b1;
                    n_state      = gsolv_pkg::S_ROW_RD;
                end
            end
            gsolv_pkg::S_ROW_RD: begin
                o_raddr_a = f_addr(r_j, r_i);
                n_state   = gsolv_pkg::S_ROW_DIV;
            end
            gsolv_pkg::S_ROW_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = gsolv_pkg::S_ROW_WAIT;
            end
            gsolv_pkg::S_ROW_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.ratio_ld = 1'b1;
                    n_k            = '0;
                    n_state        = gsolv_pkg::S_K_RD;
                end
            end
            gsolv_pkg::S_K_RD: begin
                o_raddr_a    = r_back ? f_addr(r_i, r_j) : f_addr(r_j, r_k);
                o_raddr_b    = f_addr(r_i, r_k);
                o_sol_ridx   = r_j[IW-1:0];
                o_cmd.sol_rd = 1'b1;
                n_state      = gsolv_pkg::S_K_MUL;
            end
            gsolv_pkg::S_K_MUL: begin
                o_cmd.mul_ld = 1'b1;
                n_state      = gsolv_pkg::S_K_WR;
            end
            gsolv_pkg::S_K_WR: begin
                if (r_back) begin
                    o_cmd.acc_ld_ms = 1'b1;
                    if (r_j == n_m1) begin
                        n_state = gsolv_pkg::S_B_DIV;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = gsolv_pkg::S_K_RD;
                    end
                end else begin
                    o_cmd.mem_we = 1'b1;
                    o_waddr      = f_addr(r_j, r_k);
                    if (r_k != i_n) begin
                        n_k     = r_k + 1'b1;
                        n_state = gsolv_pkg::S_K_RD;
                    end else if (r_j != n_m1) begin
                        n_j     = r_j + 1'b1;
                        n_state = gsolv_pkg::S_ROW_RD;
                    end else if (r_i + 1'b1 != n_m1) begin
                        n_i     = r_i + 1'b1;
                        n_state = gsolv_pkg::S_PIV_RD;
                    end else begin
                        n_state = gsolv_pkg::S_LAST_RD;
                    end
                end
            end
            gsolv_pkg::S_LAST_RD: begin
                o_raddr_b = f_addr(n_m1, n_m1);
                n_state   = gsolv_pkg::S_LAST_CHK;
            end
            gsolv_pkg::S_LAST_CHK: begin
                if (i_sts.rd_b_zero) begin
                    n_state = gsolv_pkg::S_ERR;
                end else begin
                    n_i     = n_m1;
                    n_back  = 1'b1;
                    n_state = gsolv_pkg::S_B_RD;
                end
            end
            gsolv_pkg::S_B_RD: begin
                o_raddr_a = f_addr(r_i, i_n);
                o_raddr_b = f_addr(r_i, r_i);
                n_state   = gsolv_pkg::S_B_ACC;
            end
            gsolv_pkg::S_B_ACC: begin
                o_cmd.acc_ld_mem = 1'b1;
                o_cmd.piv_ld     = 1'b1;
                n_j              = r_i + 1'b1;
                n_state = (r_i == n_m1) ? gsolv_pkg::S_B_DIV : gsolv_pkg::S_K_RD;
            end
            gsolv_pkg::S_B_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = gsolv_pkg::S_B_WAIT;
            end
            gsolv_pkg::S_B_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.sol_we = 1'b1;
                    o_sol_widx   = r_i[IW-1:0];
                    if (r_i == '0) begin
                        n_state = gsolv_pkg::S_EMIT;
                    end else begin
                        n_i     = r_i - 1'b1;
                        n_state = gsolv_pkg::S_B_RD;
                    end
                end
            end
            gsolv_pkg::S_EMIT: begin
                o_sol_ridx = r_i[IW-1:0];
                o_out_idx  = r_i;
                if (i_sts.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_last = (r_i == n_m1);
                    if (r_i == n_m1) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_back  = 1'b0;
                        n_state = gsolv_pkg::S_LOAD;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            gsolv_pkg::S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_sing = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_back  = 1'b0;
                    n_state = gsolv_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = gsolv_pkg::S_LOAD;
            end
        endcase
    end

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider started while busy");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> i_sts.out_free)
        else $error("result loaded over a pending result");

    a_last_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_ld && o_cmd.out_last) |=> (r_state == gsolv_pkg::S_LOAD))
        else $error("run did not return to loading after its last result");

    a_sing_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_sing |-> o_cmd.out_last)
        else $error("singular result not marked last");

endmodule

// ----- rtl/linear_system_gauss_solver.sv -----
// linear system solver top level: configuration registers and controller/datapath
//
// usage: write the order register (n unknowns, 0 acts as 1, above MAX_ORDER acts
// as MAX_ORDER) over the apb port; a write while loading also restarts loading. then send the
// augmented matrix row-major on the input channel, n*(n+1) signed q16.16 elements,
// one request per cycle while o_in_stall is low.
// after the last element the block stalls its input and solves: forward
// elimination without pivoting, then back substitution. each ratio and each
// solution is a 48-step serial divide, and each multiply-subtract goes through
// the single multiplier, whose product is registered before the subtract.
// results leave one per cycle while i_out_stall is low, as n requests with
// index 0..n-1 and last on the final one, or a single request with singular
// and last set if a pivot is zero. a stalled result holds its payload; the
// solver waits for it to drain before the next one. loading of the next
// system resumes once the last result is in the output register. reset sets
// the order to 3 and empties the load position; the matrix memory is not cleared.
module linear_system_gauss_solver #(
    parameter int MAX_ORDER = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gsolv_pkg::CFG_AW-1:0]      paddr,
    input  logic [gsolv_pkg::CFG_DW-1:0]      pwdata,
    output logic [gsolv_pkg::CFG_DW-1:0]      prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    input  logic signed [gsolv_pkg::DW-1:0]   i_element,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output logic signed [gsolv_pkg::DW-1:0]   o_solution,
    output logic [gsolv_pkg::OUT_IW-1:0]      o_index,
    output logic                              o_singular,
    output logic                              o_last,
    input  logic                              i_out_stall
);
    localparam int AW = $clog2(MAX_ORDER * (MAX_ORDER + 1));
    localparam int NW = $clog2(MAX_ORDER + 1);
    localparam int IW = $clog2(MAX_ORDER);
    localparam int OW = gsolv_pkg::OW;

    logic [OW-1:0] r_order;
    logic          cfg_wr;
    logic [NW-1:0] eff_n;

    gsolv_pkg::t_cmd cmd;
    gsolv_pkg::t_sts sts;
    logic [AW-1:0]   waddr, raddr_a, raddr_b;
    logic [IW-1:0]   sol_widx, sol_ridx;
    logic [NW-1:0]   out_idx;
    logic [gsolv_pkg::DW-1:0] solution;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[gsolv_pkg::CFG_AW-1:2] == 1'(gsolv_pkg::REG_ORDER));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= gsolv_pkg::ORDER_RESET;
        end else if (cfg_wr) begin
            r_order <= pwdata[OW-1:0];
        end
    end

    always_comb begin
        if (paddr[gsolv_pkg::CFG_AW-1:2] == 1'(gsolv_pkg::REG_ORDER)) begin
            prdata = gsolv_pkg::CFG_DW'(r_order);
        end else begin
            prdata = '0;
        end
    end

    always_comb begin
        if (r_order == '0) begin
            eff_n = NW'(1);
        end else if (32'(r_order) > MAX_ORDER) begin
            eff_n = NW'(MAX_ORDER);
        end else begin
            eff_n = NW'(r_order);
        end
    end

    gsolv_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_n        (eff_n),
        .i_cfg_wr   (cfg_wr),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_waddr    (waddr),
        .o_raddr_a  (raddr_a),
        .o_raddr_b  (raddr_b),
        .o_sol_widx (sol_widx),
        .o_sol_ridx (sol_ridx),
        .o_out_idx  (out_idx)
    );

    gsolv_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_waddr     (waddr),
        .i_raddr_a   (raddr_a),
        .i_raddr_b   (raddr_b),
        .i_sol_widx  (sol_widx),
        .i_sol_ridx  (sol_ridx),
        .i_out_idx   (out_idx),
        .i_element   (i_element),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_solution  (solution),
        .o_index     (o_index),
        .o_singular  (o_singular),
        .o_last      (o_last)
    );

    assign o_solution = $signed(solution);

endmodule
